### src/aesp_pkg.sv
// Types and constants for the angle encoder SPI poller.
package aesp_pkg;

  // Poll state kept for each encoder
  typedef enum logic [1:0] {
    POLL_ANGLE = 2'd0,
    POLL_ERRFL = 2'd1,
    POLL_DIAG  = 2'd2
  } poll_t;

  // Read command issued to an encoder
  typedef enum logic [1:0] {
    CMD_ANGLE = 2'd0,
    CMD_ERRFL = 2'd1,
    CMD_DIAG  = 2'd2
  } cmd_t;

  // Latched error code
  typedef enum logic [1:0] {
    KIND_NONE  = 2'd0,
    KIND_LINK  = 2'd1,
    KIND_ERRFL = 2'd2,
    KIND_DIAG  = 2'd3
  } kind_t;

  // Configuration register indexes
  localparam logic [1:0] CFG_PIPELINED = 2'd0;
  localparam logic [1:0] CFG_FULL_DIAG = 2'd1;
  localparam logic [1:0] CFG_MAX_RECOV = 2'd2;

  // Command words with read bit and even parity already in place
  localparam logic [15:0] WORD_ANGLE = 16'hFFFF;
  localparam logic [15:0] WORD_ERRFL = 16'h4001;
  localparam logic [15:0] WORD_DIAG  = 16'hFFFC;

  // Frames that mean the link is dead
  localparam logic [15:0] FRAME_LOW  = 16'h0000;
  localparam logic [15:0] FRAME_HIGH = 16'hFFFF;

  // Detail latched on a parity failure
  localparam logic [11:0] DETAIL_PARITY = 12'h004;

  localparam logic [7:0] RETRY_MAX = 8'hFF;

endpackage

### src/angle_encoder_spi_poller_top.sv
// Angle encoder SPI poller: per-encoder command choice and frame decode.
//
//  channel  handshake                  payload
//  -------  -------------------------  --------------------------------------------
//  in       in_valid / in_stall        encoder_index, rx_frame, link_ok
//  out      out_valid / out_stall      tx_command, angle, angle_valid, error_flag,
//                                      error_kind, error_detail
//  cfg      cfg_write                  cfg_index, cfg_data
//
// One request per cycle sustained while out_stall is low; a request passes through the input
// register, then the decode into the result register.
// Per-encoder state sits in flip-flops, read and written in the decode cycle,
// so requests to the same encoder follow each other with no gap.
// Reset clears all per-encoder state and loads the register defaults at once.
// A stalled result holds the decode stage; the input register then stalls in turn.
module angle_encoder_spi_poller_top #(
  parameter int NUM_ENCODERS = 32
) (
  input  logic        clk,
  input  logic        rst,
  // configuration
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  // request channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [4:0]  encoder_index,
  input  logic [15:0] rx_frame,
  input  logic        link_ok,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] tx_command,
  output logic [13:0] angle,
  output logic        angle_valid,
  output logic        error_flag,
  output logic [1:0]  error_kind,
  output logic [11:0] error_detail
);

  localparam int IDX_W = (NUM_ENCODERS > 1) ? $clog2(NUM_ENCODERS) : 1;

  // configuration registers
  logic       pipelined_mode;
  logic       full_diag;
  logic [7:0] retry_limit;

  // per-encoder state
  aesp_pkg::poll_t poll_state     [NUM_ENCODERS];
  aesp_pkg::cmd_t  last_command   [NUM_ENCODERS];
  aesp_pkg::kind_t latched_kind   [NUM_ENCODERS];
  logic [11:0]     latched_detail [NUM_ENCODERS];
  logic [7:0]      retry_count    [NUM_ENCODERS];

  // input register
  logic        s1_valid;
  logic [4:0]  s1_index;
  logic [15:0] s1_frame;
  logic        s1_link;

  // handshake
  logic pipe_move;
  logic in_take;
  logic s1_fire;

  // decode signals
  logic [8:0]       idx_ext;
  logic [8:0]       id_ext;
  logic             in_range;
  logic [IDX_W-1:0] id;
  aesp_pkg::poll_t  cur_poll;
  aesp_pkg::cmd_t   cur_last;
  aesp_pkg::kind_t  cur_kind;
  logic [11:0]      cur_detail;
  logic [7:0]       cur_retry;
  logic [7:0]       retry_bump;
  aesp_pkg::cmd_t   issued;
  aesp_pkg::cmd_t   against;
  logic             dead_link;
  logic             parity_bad;
  logic [15:0]      word_next;

  aesp_pkg::poll_t  poll_next;
  aesp_pkg::cmd_t   last_next;
  aesp_pkg::kind_t  kind_next;
  logic [11:0]      detail_next;
  logic [7:0]       retry_next;
  logic             eflag_next;
  logic             valid_next;
  logic [13:0]      angle_next;

  // handshake: result register frees up when empty or taken
  assign pipe_move = !out_valid || !out_stall;
  assign in_stall  = s1_valid && !pipe_move;
  assign in_take   = in_valid && !in_stall;
  assign s1_fire   = s1_valid && pipe_move;

  // encoder select, clamped to the last encoder when out of range
  assign idx_ext  = 9'(s1_index);
  assign in_range = idx_ext < 9'(NUM_ENCODERS);
  assign id_ext   = in_range ? idx_ext : 9'(NUM_ENCODERS - 1);
  assign id       = id_ext[IDX_W-1:0];

  assign cur_poll   = poll_state[id];
  assign cur_last   = last_command[id];
  assign cur_kind   = latched_kind[id];
  assign cur_detail = latched_detail[id];
  assign cur_retry  = retry_count[id];

  assign retry_bump = (cur_retry == aesp_pkg::RETRY_MAX) ? cur_retry : cur_retry + 8'd1;
  assign dead_link  = !s1_link || (s1_frame == aesp_pkg::FRAME_LOW) ||
                      (s1_frame == aesp_pkg::FRAME_HIGH);
  assign parity_bad = (^s1_frame[14:0]) != s1_frame[15];

  // next command from the state before decode
  always_comb begin
    case (cur_poll)
      aesp_pkg::POLL_ERRFL: issued = aesp_pkg::CMD_ERRFL;
      aesp_pkg::POLL_DIAG:  issued = full_diag ? aesp_pkg::CMD_DIAG : aesp_pkg::CMD_ANGLE;
      default:              issued = aesp_pkg::CMD_ANGLE;
    endcase
  end

  always_comb begin
    unique case (issued)
      aesp_pkg::CMD_ERRFL: word_next = aesp_pkg::WORD_ERRFL;
      aesp_pkg::CMD_DIAG:  word_next = aesp_pkg::WORD_DIAG;
      default:             word_next = aesp_pkg::WORD_ANGLE;
    endcase
  end

  // frame decode
  always_comb begin
    against     = pipelined_mode ? cur_last : issued;
    last_next   = pipelined_mode ? issued : cur_last;
    poll_next   = cur_poll;
    kind_next   = cur_kind;
    detail_next = cur_detail;
    retry_next  = cur_retry;
    eflag_next  = 1'b0;
    valid_next  = 1'b0;
    angle_next  = '0;
    if (dead_link) begin
      eflag_next  = 1'b1;
      kind_next   = aesp_pkg::KIND_LINK;
      detail_next = '0;
      retry_next  = retry_bump;
      if (retry_bump >= retry_limit) begin
        poll_next = aesp_pkg::POLL_ANGLE;
      end
    end else if (parity_bad) begin
      eflag_next  = 1'b1;
      kind_next   = aesp_pkg::KIND_ERRFL;
      detail_next = aesp_pkg::DETAIL_PARITY;
      poll_next   = aesp_pkg::POLL_ERRFL;
    end else begin
      case (against)
        aesp_pkg::CMD_ANGLE: begin
          if (s1_frame[14]) begin
            eflag_next = 1'b1;
            poll_next  = aesp_pkg::POLL_ERRFL;
          end else begin
            valid_next = 1'b1;
            angle_next = s1_frame[13:0];
            retry_next = '0;
            if (cur_kind != aesp_pkg::KIND_LINK) begin
              kind_next   = aesp_pkg::KIND_NONE;
              detail_next = '0;
            end
            poll_next = aesp_pkg::POLL_ANGLE;
          end
        end
        aesp_pkg::CMD_ERRFL: begin
          eflag_next = 1'b1;
          if (|s1_frame[2:0]) begin
            kind_next   = aesp_pkg::KIND_ERRFL;
            detail_next = {8'd0, s1_frame[3:0]};
          end
          poll_next = full_diag ? aesp_pkg::POLL_DIAG : aesp_pkg::POLL_ANGLE;
        end
        aesp_pkg::CMD_DIAG: begin
          eflag_next = 1'b1;
          if (|s1_frame[11:8]) begin
            kind_next   = aesp_pkg::KIND_DIAG;
            detail_next = s1_frame[11:0];
          end
          retry_next = retry_bump;
          poll_next  = aesp_pkg::POLL_ANGLE;
        end
        default: begin
          poll_next = aesp_pkg::POLL_ANGLE;
        end
      endcase
    end
  end

  // control, configuration and per-encoder state
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid       <= 1'b0;
      out_valid      <= 1'b0;
      pipelined_mode <= 1'b1;
      full_diag      <= 1'b1;
      retry_limit    <= 8'd3;
      for (int i = 0; i < NUM_ENCODERS; i++) begin
        poll_state[i]     <= aesp_pkg::POLL_ANGLE;
        last_command[i]   <= aesp_pkg::CMD_ANGLE;
        latched_kind[i]   <= aesp_pkg::KIND_NONE;
        latched_detail[i] <= '0;
        retry_count[i]    <= '0;
      end
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          aesp_pkg::CFG_PIPELINED: pipelined_mode <= cfg_data[0];
          aesp_pkg::CFG_FULL_DIAG: full_diag      <= cfg_data[0];
          aesp_pkg::CFG_MAX_RECOV: retry_limit    <= cfg_data;
          default: ;
        endcase
      end
      if (in_take) begin
        s1_valid <= 1'b1;
      end else if (pipe_move) begin
        s1_valid <= 1'b0;
      end
      if (pipe_move) begin
        out_valid <= s1_valid;
      end
      if (s1_fire && in_range) begin
        poll_state[id]     <= poll_next;
        last_command[id]   <= last_next;
        latched_kind[id]   <= kind_next;
        latched_detail[id] <= detail_next;
        retry_count[id]    <= retry_next;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_index <= encoder_index;
      s1_frame <= rx_frame;
      s1_link  <= link_ok;
    end
    if (s1_fire) begin
      tx_command <= word_next;
      if (in_range) begin
        angle        <= angle_next;
        angle_valid  <= valid_next;
        error_flag   <= eflag_next;
        error_kind   <= kind_next;
        error_detail <= detail_next;
      end else begin
        angle        <= '0;
        angle_valid  <= 1'b0;
        error_flag   <= 1'b0;
        error_kind   <= aesp_pkg::KIND_NONE;
        error_detail <= '0;
      end
    end
  end

endmodule

### tb/sv/angle_encoder_spi_poller_top_test.sv
// Self-checking testbench: directed and random encoder slots checked against a poller model.
`timescale 1ns / 1ps

module angle_encoder_spi_poller_top_test;

  localparam int ENCODERS  = 32;
  localparam int LONG_HOLD = 80;
  localparam int PHASES    = 5;
  localparam int PER_PHASE = 45;

  // Register settings per phase, phase 0 in the low bits
  localparam logic [PHASES-1:0] PHASE_PIPE  = 5'b11010;
  localparam logic [PHASES-1:0] PHASE_DIAG  = 5'b11001;
  localparam logic [8*PHASES-1:0] PHASE_LIMIT = {8'd255, 8'd1, 8'd2, 8'd255, 8'd1};

  typedef struct packed {
    logic [15:0]     cmd;
    logic [13:0]     ang;
    logic            ang_ok;
    logic            err;
    aesp_pkg::kind_t kind;
    logic [11:0]     detail;
  } slot_result_t;

  typedef struct packed {
    logic [4:0]   enc;
    logic [15:0]  frame;
    logic         link;
    logic         known;
    slot_result_t want;
  } slot_row_t;

  localparam slot_result_t NO_WANT = '0;

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_write;
  logic [1:0]  cfg_index;
  logic [7:0]  cfg_data;
  logic        in_valid;
  logic        in_stall;
  logic [4:0]  encoder_index;
  logic [15:0] rx_frame;
  logic        link_ok;
  logic        out_valid;
  logic        out_stall;
  logic [15:0] tx_command;
  logic [13:0] angle;
  logic        angle_valid;
  logic        error_flag;
  logic [1:0]  error_kind;
  logic [11:0] error_detail;

  angle_encoder_spi_poller_top #(.NUM_ENCODERS(ENCODERS)) dut (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .encoder_index(encoder_index), .rx_frame(rx_frame), .link_ok(link_ok),
    .out_valid(out_valid), .out_stall(out_stall),
    .tx_command(tx_command), .angle(angle), .angle_valid(angle_valid),
    .error_flag(error_flag), .error_kind(error_kind), .error_detail(error_detail)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Per-encoder poller state and register copies
  aesp_pkg::poll_t enc_poll     [ENCODERS];
  aesp_pkg::cmd_t  enc_last_cmd [ENCODERS];
  aesp_pkg::kind_t enc_kind     [ENCODERS];
  logic [11:0]     enc_detail   [ENCODERS];
  logic [7:0]      enc_retries  [ENCODERS];
  logic            pipelined_en   = 1'b1;
  logic            full_diag_en   = 1'b1;
  logic [7:0]      recovery_limit = 8'd3;

  slot_result_t pending_results[$];
  slot_row_t    directed_rows[$];
  int           mismatches    = 0;
  int           burst_left    = 0;
  bit           long_hold_req = 1'b0;

  // Read command word: address, read bit, even parity on top
  function automatic logic [15:0] command_word(aesp_pkg::cmd_t c);
    logic [14:0] word;
    case (c)
      aesp_pkg::CMD_ERRFL: word = 15'h0001;
      aesp_pkg::CMD_DIAG:  word = 15'h3FFC;
      default:             word = 15'h3FFF;
    endcase
    word[14] = 1'b1;
    return {^word, word};
  endfunction

  // Frame with correct parity
  function automatic logic [15:0] even_frame(logic err, logic [13:0] pay);
    return {^{err, pay}, err, pay};
  endfunction

  // Issue a command and decode one slot, updating the encoder's state
  function automatic slot_result_t decode_slot(logic [4:0] enc, logic [15:0] frame,
                                               logic link);
    slot_result_t   r;
    aesp_pkg::cmd_t issued;
    aesp_pkg::cmd_t against;
    logic [13:0]    pay;
    r = '0;
    pay = frame[13:0];
    if (enc_poll[enc] == aesp_pkg::POLL_ERRFL)
      issued = aesp_pkg::CMD_ERRFL;
    else if (enc_poll[enc] == aesp_pkg::POLL_DIAG && full_diag_en)
      issued = aesp_pkg::CMD_DIAG;
    else
      issued = aesp_pkg::CMD_ANGLE;
    r.cmd = command_word(issued);
    against = issued;
    if (pipelined_en) begin
      against = enc_last_cmd[enc];
      enc_last_cmd[enc] = issued;
    end

    if (!link || frame == aesp_pkg::FRAME_LOW || frame == aesp_pkg::FRAME_HIGH) begin
      // dead link: count a retry, give up on the error walk once at the limit
      r.err = 1'b1;
      enc_kind[enc] = aesp_pkg::KIND_LINK;
      enc_detail[enc] = '0;
      if (enc_retries[enc] != aesp_pkg::RETRY_MAX) enc_retries[enc]++;
      if (enc_retries[enc] >= recovery_limit) enc_poll[enc] = aesp_pkg::POLL_ANGLE;
    end else if ((^frame[14:0]) != frame[15]) begin
      r.err = 1'b1;
      enc_kind[enc] = aesp_pkg::KIND_ERRFL;
      enc_detail[enc] = aesp_pkg::DETAIL_PARITY;
      enc_poll[enc] = aesp_pkg::POLL_ERRFL;
    end else begin
      case (against)
        aesp_pkg::CMD_ANGLE: begin
          if (frame[14]) begin
            r.err = 1'b1;
            enc_poll[enc] = aesp_pkg::POLL_ERRFL;
          end else begin
            r.ang = pay;
            r.ang_ok = 1'b1;
            enc_retries[enc] = '0;
            // a link-lost latch survives a good angle
            if (enc_kind[enc] != aesp_pkg::KIND_LINK) begin
              enc_kind[enc] = aesp_pkg::KIND_NONE;
              enc_detail[enc] = '0;
            end
            enc_poll[enc] = aesp_pkg::POLL_ANGLE;
          end
        end
        aesp_pkg::CMD_ERRFL: begin
          r.err = 1'b1;
          if (|pay[2:0]) begin
            enc_kind[enc] = aesp_pkg::KIND_ERRFL;
            enc_detail[enc] = {8'd0, pay[3:0]};
          end
          if (full_diag_en)
            enc_poll[enc] = aesp_pkg::POLL_DIAG;
          else
            enc_poll[enc] = aesp_pkg::POLL_ANGLE;
        end
        aesp_pkg::CMD_DIAG: begin
          r.err = 1'b1;
          if (|pay[11:8]) begin
            enc_kind[enc] = aesp_pkg::KIND_DIAG;
            enc_detail[enc] = pay[11:0];
          end
          if (enc_retries[enc] != aesp_pkg::RETRY_MAX) enc_retries[enc]++;
          enc_poll[enc] = aesp_pkg::POLL_ANGLE;
        end
        default: enc_poll[enc] = aesp_pkg::POLL_ANGLE;
      endcase
    end
    r.kind = enc_kind[enc];
    r.detail = enc_detail[enc];
    return r;
  endfunction

  // Offer one request in bursts with random gaps; log its expected result when taken
  task automatic offer_slot(logic [4:0] enc, logic [15:0] frame, logic link, logic known,
                            slot_result_t want);
    slot_result_t predicted;
    int           gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 30);
    end
    burst_left--;
    in_valid      <= 1'b1;
    encoder_index <= enc;
    rx_frame      <= frame;
    link_ok       <= link;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted = decode_slot(enc, frame, link);
    pending_results.push_back(known ? want : predicted);
  endtask

  // Random request: mostly well-formed frames, some link loss, bad parity and noise
  task automatic random_slot();
    int          pick;
    logic [4:0]  enc;
    logic [15:0] frame;
    logic        link;
    logic [13:0] pay;
    if ($urandom_range(0, 4) != 0)
      enc = 5'($urandom_range(0, 3));
    else
      enc = 5'($urandom_range(0, ENCODERS - 1));
    frame = 16'($urandom);
    link = 1'b1;
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      link = 1'b0;
    end else if (pick < 12) begin
      frame = ($urandom_range(0, 1) != 0) ? aesp_pkg::FRAME_HIGH : aesp_pkg::FRAME_LOW;
    end else if (pick < 20) begin
      frame[15] = ~(^frame[14:0]);
    end else if (pick < 30) begin
      link = ($urandom_range(0, 9) != 0);
    end else begin
      case ($urandom_range(0, 2))
        0:       pay = 14'($urandom);
        1:       pay = 14'($urandom_range(1, 15));
        default: pay = {2'b00, 4'($urandom), 8'($urandom)};
      endcase
      frame = even_frame($urandom_range(0, 4) == 0, pay);
    end
    offer_slot(enc, frame, link, 1'b0, NO_WANT);
  endtask

  // Stop sending and wait for every expected result, plus the pipeline depth
  task automatic settle_results();
    in_valid <= 1'b0;
    burst_left = 0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write all three registers back to back while idle
  task automatic set_mode(logic pipe, logic diag, logic [7:0] limit);
    cfg_write <= 1'b1;
    cfg_index <= aesp_pkg::CFG_PIPELINED;
    cfg_data  <= {7'd0, pipe};
    @(posedge clk);
    cfg_index <= aesp_pkg::CFG_FULL_DIAG;
    cfg_data  <= {7'd0, diag};
    @(posedge clk);
    cfg_index <= aesp_pkg::CFG_MAX_RECOV;
    cfg_data  <= limit;
    @(posedge clk);
    cfg_write <= 1'b0;
    pipelined_en   = pipe;
    full_diag_en   = diag;
    recovery_limit = limit;
  endtask

  task automatic compare_field(string name, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s expected %h, got %h", $time, name, want, got);
    end
  endtask

  // Result checker
  always @(posedge clk) begin : result_check
    slot_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result, tx_command %h", $time, tx_command);
      end else begin
        want = pending_results.pop_front();
        compare_field("tx_command", want.cmd, tx_command);
        compare_field("angle", 16'(want.ang), 16'(angle));
        compare_field("angle_valid", 16'(want.ang_ok), 16'(angle_valid));
        compare_field("error_flag", 16'(want.err), 16'(error_flag));
        compare_field("error_kind", 16'(want.kind), 16'(error_kind));
        compare_field("error_detail", 16'(want.detail), 16'(error_detail));
      end
    end
  end

  // Receiver stall: rotating patterns, plus a long hold on request
  initial begin : result_stall
    int rx_cycle;
    rx_cycle = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      rx_cycle++;
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        out_stall <= 1'b0;
      end else begin
        case ((rx_cycle / 64) % 4)
          0:       out_stall <= 1'b0;
          1:       out_stall <= ($urandom_range(0, 1) != 0);
          2:       out_stall <= (rx_cycle % 3 == 0);
          default: out_stall <= ($urandom_range(0, 4) == 0);
        endcase
      end
    end
  end

  // Stimulus
  initial begin : stimulus
    int p;
    int n;
    for (n = 0; n < ENCODERS; n++) begin
      enc_poll[n]     = aesp_pkg::POLL_ANGLE;
      enc_last_cmd[n] = aesp_pkg::CMD_ANGLE;
      enc_kind[n]     = aesp_pkg::KIND_NONE;
      enc_detail[n]   = '0;
      enc_retries[n]  = '0;
    end
    rst           <= 1'b1;
    cfg_write     <= 1'b0;
    cfg_index     <= aesp_pkg::CFG_PIPELINED;
    cfg_data      <= '0;
    in_valid      <= 1'b0;
    encoder_index <= '0;
    rx_frame      <= '0;
    link_ok       <= 1'b0;

    // Directed slots under the reset register values
    // dead link three ways, then a good angle keeps the link-lost latch
    directed_rows.push_back('{5'd0, 16'h0000, 1'b1, 1'b1,
                              '{16'hFFFF, 14'h0, 1'b0, 1'b1, aesp_pkg::KIND_LINK, 12'h0}});
    directed_rows.push_back('{5'd0, 16'hFFFF, 1'b1, 1'b1,
                              '{16'hFFFF, 14'h0, 1'b0, 1'b1, aesp_pkg::KIND_LINK, 12'h0}});
    directed_rows.push_back('{5'd0, 16'h1234, 1'b0, 1'b1,
                              '{16'hFFFF, 14'h0, 1'b0, 1'b1, aesp_pkg::KIND_LINK, 12'h0}});
    directed_rows.push_back('{5'd0, 16'h3FFF, 1'b1, 1'b1,
                              '{16'hFFFF, 14'h3FFF, 1'b1, 1'b0, aesp_pkg::KIND_LINK, 12'h0}});
    directed_rows.push_back('{5'd0, 16'h8001, 1'b1, 1'b0, NO_WANT});
    // parity failure, angle with error bit, error flags, diagnostics, back to angle
    directed_rows.push_back('{5'd0, 16'h0001, 1'b1, 1'b1,
                              '{16'hFFFF, 14'h0, 1'b0, 1'b1, aesp_pkg::KIND_ERRFL, 12'h004}});
    directed_rows.push_back('{5'd0, 16'hC123, 1'b1, 1'b0, NO_WANT});
    directed_rows.push_back('{5'd0, 16'hC00F, 1'b1, 1'b0, NO_WANT});
    directed_rows.push_back('{5'd0, 16'h8008, 1'b1, 1'b0, NO_WANT});
    directed_rows.push_back('{5'd0, 16'h0FFF, 1'b1, 1'b0, NO_WANT});
    directed_rows.push_back('{5'd0, 16'h00FF, 1'b1, 1'b0, NO_WANT});
    directed_rows.push_back('{5'd0, 16'hAAAA, 1'b1, 1'b0, NO_WANT});
    // top encoder: parity failures at the frame extremes, then link loss in the walk
    directed_rows.push_back('{5'd31, 16'h7FFF, 1'b1, 1'b1,
                              '{16'hFFFF, 14'h0, 1'b0, 1'b1, aesp_pkg::KIND_ERRFL, 12'h004}});
    directed_rows.push_back('{5'd31, 16'h8000, 1'b1, 1'b1,
                              '{16'h4001, 14'h0, 1'b0, 1'b1, aesp_pkg::KIND_ERRFL, 12'h004}});
    directed_rows.push_back('{5'd31, 16'h4007, 1'b1, 1'b0, NO_WANT});
    directed_rows.push_back('{5'd31, 16'h1234, 1'b0, 1'b0, NO_WANT});
    directed_rows.push_back('{5'd31, 16'hFFFF, 1'b1, 1'b0, NO_WANT});
    directed_rows.push_back('{5'd31, 16'h0000, 1'b1, 1'b1,
                              '{16'hFFFC, 14'h0, 1'b0, 1'b1, aesp_pkg::KIND_LINK, 12'h0}});
    directed_rows.push_back('{5'd31, 16'h8100, 1'b1, 1'b0, NO_WANT});
    directed_rows.push_back('{5'd17, 16'h9555, 1'b1, 1'b1,
                              '{16'hFFFF, 14'h1555, 1'b1, 1'b0, aesp_pkg::KIND_NONE, 12'h0}});
    directed_rows.push_back('{5'd0, 16'hFFFF, 1'b0, 1'b0, NO_WANT});

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i])
      offer_slot(directed_rows[i].enc, directed_rows[i].frame, directed_rows[i].link,
                 directed_rows[i].known, directed_rows[i].want);
    settle_results();

    // Random phases under different register settings
    for (p = 0; p < PHASES; p++) begin
      set_mode(PHASE_PIPE[p], PHASE_DIAG[p], PHASE_LIMIT[p*8 +: 8]);
      for (n = 0; n < PER_PHASE; n++) begin
        if (p == 1 && n == 20) begin
          // long receiver hold while the sender keeps offering
          long_hold_req = 1'b1;
          burst_left = 40;
        end
        if (p == 3 && n == 25) settle_results();
        random_slot();
      end
      if (p == PHASES - 1) begin
        // retry count saturation: a wrapped count would leave the error walk going
        repeat (258) offer_slot(5'd9, 16'h1234, 1'b0, 1'b0, NO_WANT);
        offer_slot(5'd9, 16'h0001, 1'b1, 1'b0, NO_WANT);
        offer_slot(5'd9, aesp_pkg::FRAME_LOW, 1'b1, 1'b0, NO_WANT);
        offer_slot(5'd9, 16'h8001, 1'b1, 1'b0, NO_WANT);
      end
      settle_results();
    end

    if (mismatches == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
